/* hw/rtl/bmct_pkg.sv */
// Shared types, constants and helpers for the binary mask centroid tracker.
// No dependencies; used by bmct_iter_unit and binary_mask_centroid_tracker_core.
package bmct_pkg;

    localparam int SUM_W    = 30;   // coordinate sums
    localparam int CNT_W    = 21;   // set pixel count
    localparam int POS_W    = 10;   // tracked position
    localparam int DIM_W    = 11;   // width, height, diagonal registers
    localparam int PIX_W    = 21;   // frame pixel count register
    localparam int CFG_W    = 21;   // config data bus
    localparam int SQ_W     = 20;   // one squared distance term
    localparam int RAD_W    = 22;   // radicand width seen by the square root
    localparam int REM_W    = 22;   // partial remainder
    localparam int ROOT_W   = 11;
    localparam int ROOT5_W  = 14;
    localparam int PROD_W   = CNT_W + 8;
    localparam int STEP_W   = 5;

    localparam logic [STEP_W-1:0] DIV_STEPS  = STEP_W'(SUM_W);
    localparam logic [STEP_W-1:0] SQRT_STEPS = STEP_W'(RAD_W / 2);
    localparam logic [POS_W-1:0]  POS_MAX    = '1;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_FRAME_WIDTH  = 2'd0;
    localparam t_cfg_idx CFG_FRAME_HEIGHT = 2'd1;
    localparam t_cfg_idx CFG_FRAME_PIXELS = 2'd2;
    localparam t_cfg_idx CFG_DIAGONAL     = 2'd3;

    localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = DIM_W'(320);
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = DIM_W'(240);
    localparam logic [PIX_W-1:0] RST_FRAME_PIXELS = PIX_W'(76800);
    localparam logic [DIM_W-1:0] RST_DIAGONAL     = DIM_W'(400);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CENTROID,
        ST_DIV_COL,
        ST_DIV_ROW,
        ST_GATE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_ROOT_START,
        ST_SQRT,
        ST_FINISH
    } t_state;

    typedef enum logic {
        ITER_DIV,
        ITER_SQRT
    } t_iter_mode;

    typedef struct packed {
        logic       start;
        t_iter_mode mode;
    } t_iter_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_iter_stat;

    // Quotient clamp to the position range.
    function automatic logic [POS_W-1:0] f_clamp_pos(input logic [SUM_W-1:0] q);
        return (|q[SUM_W-1:POS_W]) ? POS_MAX : q[POS_W-1:0];
    endfunction

    // 200 * count > pixels, with 200 = 128 + 64 + 8.
    function automatic logic f_present(input logic [CNT_W-1:0] cnt,
                                       input logic [PIX_W-1:0] pixels);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'({cnt, 7'b0}) + PROD_W'({cnt, 6'b0}) + PROD_W'({cnt, 3'b0});
        return prod > PROD_W'(pixels);
    endfunction

endpackage

/* hw/rtl/binary_mask_centroid_tracker_core.sv */
// Top level of the binary mask centroid tracker: pixel accumulation, frame-end sequencer,
// gate decision and result register. Depends on bmct_pkg and bmct_iter_unit.
//
//   channel   direction  handshake           word
//   pixel     in         i_valid / o_stall   i_mask_bit, i_end_of_frame, i_objects_found
//   result    out        o_valid / i_stall   o_pupil_col, o_pupil_row, o_pupil_present
//   config    in         i_cfg_we            i_cfg_index, i_cfg_data
//
// Ordinary pixels are taken one per clock while the sequencer is idle. A pixel word with
// end of frame starts the frame-end sequence: two restoring divisions, column then row,
// a square root on the shared iterative unit and control steps, during which o_stall is
// high. With no objects it goes straight to the final step; with objects but no lock yet
// the square root is skipped. The final step waits for the result register to be free,
// so a stalled result blocks only the next frame end. Reset is synchronous, active low,
// and restores the default frame geometry and an unlocked (0,0) position.
module binary_mask_centroid_tracker_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  bmct_pkg::t_cfg_idx           i_cfg_index,
    input  logic [bmct_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_mask_bit,
    input  logic                         i_end_of_frame,
    input  logic                         i_objects_found,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [bmct_pkg::POS_W-1:0]   o_pupil_col,
    output logic [bmct_pkg::POS_W-1:0]   o_pupil_row,
    output logic                         o_pupil_present
);
    import bmct_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WCW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;   // compare width, columns
    localparam int WRW = (RW + 1 > DIM_W) ? RW + 1 : DIM_W;   // compare width, rows

    // ---------------- configuration registers ----------------
    logic [DIM_W-1:0] r_frame_width;
    logic [DIM_W-1:0] r_frame_height;
    logic [PIX_W-1:0] r_frame_pixels;
    logic [DIM_W-1:0] r_diag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_frame_pixels <= RST_FRAME_PIXELS;
            r_diag         <= RST_DIAGONAL;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[DIM_W-1:0];
                CFG_FRAME_PIXELS: r_frame_pixels <= i_cfg_data[PIX_W-1:0];
                CFG_DIAGONAL:     r_diag         <= i_cfg_data[DIM_W-1:0];
                default:          r_diag         <= r_diag;
            endcase
        end
    end

    // ---------------- state ----------------
    t_state             r_state;
    t_state             n_state;

    logic [CW-1:0]      r_col_cnt;
    logic [RW-1:0]      r_row_cnt;
    logic [SUM_W-1:0]   r_col_sum;
    logic [SUM_W-1:0]   r_row_sum;
    logic [CNT_W-1:0]   r_set_cnt;

    logic               r_found;
    logic               r_take;
    logic [POS_W-1:0]   r_cx;
    logic [POS_W-1:0]   r_cy;
    logic [POS_W-1:0]   r_dx;
    logic [POS_W-1:0]   r_dy;
    logic [SQ_W-1:0]    r_sq_a;
    logic [SQ_W-1:0]    r_sq_b;

    logic [POS_W-1:0]   r_trk_col;
    logic [POS_W-1:0]   r_trk_row;
    logic               r_present;

    logic               r_o_valid;
    logic [POS_W-1:0]   r_o_col;
    logic [POS_W-1:0]   r_o_row;
    logic               r_o_present;

    logic               in_acc;
    logic               out_free;
    logic               trk_zero;

    t_iter_req          iter_req;
    t_iter_stat         iter_stat;
    logic [SUM_W-1:0]   iter_operand;
    logic [SUM_W-1:0]   iter_result;

    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_o_valid || !i_stall;
    assign trk_zero = (r_trk_col == '0) && (r_trk_row == '0);

    // ---------------- pixel accumulation ----------------
    logic [SUM_W:0]     col_add;
    logic [SUM_W:0]     row_add;
    logic [CNT_W:0]     cnt_add;
    logic [CW:0]        nc;
    logic [RW:0]        nr;
    logic               col_wrap;
    logic               row_wrap;

    always_comb begin
        col_add  = {1'b0, r_col_sum} + (SUM_W+1)'(r_col_cnt);
        row_add  = {1'b0, r_row_sum} + (SUM_W+1)'(r_row_cnt);
        cnt_add  = {1'b0, r_set_cnt} + (CNT_W+1)'(1);
        nc       = {1'b0, r_col_cnt} + (CW+1)'(1);
        nr       = {1'b0, r_row_cnt} + (RW+1)'(1);
        // a width of zero wraps on every pixel, same as a width of one
        col_wrap = (WCW'(nc) >= WCW'(r_frame_width)) || (nc >= (CW+1)'(MAX_WIDTH));
        row_wrap = (WRW'(nr) >= WRW'(r_frame_height)) || (nr >= (RW+1)'(MAX_HEIGHT));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_sum <= '0;
            r_row_sum <= '0;
            r_set_cnt <= '0;
        end else if (r_state == ST_FINISH && out_free) begin
            r_col_sum <= '0;
            r_row_sum <= '0;
            r_set_cnt <= '0;
        end else if (in_acc && i_mask_bit) begin
            // saturate on carry out if a frame end never shows up
            r_col_sum <= col_add[SUM_W] ? '1 : col_add[SUM_W-1:0];
            r_row_sum <= row_add[SUM_W] ? '1 : row_add[SUM_W-1:0];
            r_set_cnt <= cnt_add[CNT_W] ? '1 : cnt_add[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else if (in_acc) begin
            if (i_end_of_frame) begin
                r_col_cnt <= '0;
                r_row_cnt <= '0;
            end else if (col_wrap) begin
                r_col_cnt <= '0;
                r_row_cnt <= row_wrap ? '0 : nr[RW-1:0];
            end else begin
                r_col_cnt <= nc[CW-1:0];
            end
        end
    end

    // ---------------- frame-end sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && i_end_of_frame) n_state = ST_CENTROID;
            end
            ST_CENTROID: begin
                if (!r_found)                n_state = ST_FINISH;
                else if (r_set_cnt == '0)    n_state = ST_GATE;
                else                         n_state = ST_DIV_COL;
            end
            ST_DIV_COL: begin
                if (iter_stat.done) n_state = ST_DIV_ROW;
            end
            ST_DIV_ROW: begin
                if (iter_stat.done) n_state = ST_GATE;
            end
            ST_GATE: begin
                n_state = trk_zero ? ST_FINISH : ST_SQ_X;
            end
            ST_SQ_X:       n_state = ST_SQ_Y;
            ST_SQ_Y:       n_state = ST_ROOT_START;
            ST_ROOT_START: n_state = ST_SQRT;
            ST_SQRT: begin
                if (iter_stat.done) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs: input stall and requests to the shared unit
    always_comb begin
        o_stall        = 1'b1;
        iter_req.start = 1'b0;
        iter_req.mode  = ITER_DIV;
        iter_operand   = r_col_sum;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
            end
            ST_CENTROID: begin
                iter_req.start = r_found && (r_set_cnt != '0);
            end
            ST_DIV_COL: begin
                iter_req.start = iter_stat.done;
                iter_operand   = r_row_sum;
            end
            ST_ROOT_START: begin
                iter_req.start = 1'b1;
                iter_req.mode  = ITER_SQRT;
                iter_operand   = SUM_W'(r_sq_a) + SUM_W'(r_sq_b);
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    bmct_iter_unit u_iter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (iter_req),
        .i_operand (iter_operand),
        .i_divisor (r_set_cnt),
        .o_stat    (iter_stat),
        .o_result  (iter_result)
    );

    // ---------------- centroid and gate datapath ----------------
    logic [ROOT_W-1:0]  root;
    logic [ROOT5_W-1:0] root5;

    assign root  = iter_result[ROOT_W-1:0];
    assign root5 = ROOT5_W'({root, 2'b00}) + ROOT5_W'(root);

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_acc && i_end_of_frame) r_found <= i_objects_found;
            end
            ST_CENTROID: begin
                // empty frame with objects gives a (0,0) centroid
                r_cx   <= '0;
                r_cy   <= '0;
                r_take <= 1'b0;
            end
            ST_DIV_COL: begin
                if (iter_stat.done) r_cx <= f_clamp_pos(iter_result);
            end
            ST_DIV_ROW: begin
                if (iter_stat.done) r_cy <= f_clamp_pos(iter_result);
            end
            ST_GATE: begin
                r_dx   <= (r_trk_col > r_cx) ? r_trk_col - r_cx : r_cx - r_trk_col;
                r_dy   <= (r_trk_row > r_cy) ? r_trk_row - r_cy : r_cy - r_trk_row;
                r_take <= trk_zero;   // no lock yet: take the centroid
            end
            ST_SQ_X: begin
                r_sq_a <= SQ_W'(r_dx) * SQ_W'(r_dx);
            end
            ST_SQ_Y: begin
                r_sq_b <= SQ_W'(r_dy) * SQ_W'(r_dy);
            end
            ST_SQRT: begin
                if (iter_stat.done) r_take <= root5 < ROOT5_W'(r_diag);
            end
            default: begin
                r_take <= r_take;
            end
        endcase
    end

    // ---------------- tracked position and result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trk_col <= '0;
            r_trk_row <= '0;
            r_present <= 1'b0;
        end else if (r_state == ST_FINISH && out_free && r_take) begin
            r_trk_col <= r_cx;
            r_trk_row <= r_cy;
            r_present <= f_present(r_set_cnt, r_frame_pixels);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == ST_FINISH && out_free) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FINISH && out_free) begin
            r_o_col     <= r_take ? r_cx : r_trk_col;
            r_o_row     <= r_take ? r_cy : r_trk_row;
            r_o_present <= r_take ? f_present(r_set_cnt, r_frame_pixels) : r_present;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_pupil_col     = r_o_col;
    assign o_pupil_row     = r_o_row;
    assign o_pupil_present = r_o_present;

    // ---------------- assertions ----------------
    a_eof_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_end_of_frame) |=> o_stall)
        else $error("pixel accepted right after a frame end word");

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == ST_FINISH))
        else $error("result word raised outside the final step");

    a_track_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && r_state != ST_FINISH) |=> ($stable(r_trk_col) && $stable(r_trk_row)))
        else $error("tracked position moved outside the final step");

    a_unit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !iter_stat.busy)
        else $error("shared unit busy while taking pixels");

endmodule

/* hw/rtl/bmct_iter_unit.sv */
// Shared iterative compare-subtract unit: restoring divide or integer square root.
// Depends on bmct_pkg.
module bmct_iter_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bmct_pkg::t_iter_req        i_req,
    input  logic [bmct_pkg::SUM_W-1:0] i_operand,
    input  logic [bmct_pkg::CNT_W-1:0] i_divisor,
    output bmct_pkg::t_iter_stat       o_stat,
    output logic [bmct_pkg::SUM_W-1:0] o_result
);
    import bmct_pkg::*;

    logic              r_busy;
    logic [STEP_W-1:0] r_cnt;
    t_iter_mode        r_mode;
    logic [SUM_W-1:0]  r_acc;
    logic [REM_W-1:0]  r_rem;
    logic [SUM_W-1:0]  r_q;
    logic [CNT_W-1:0]  r_div;

    logic [REM_W-1:0]  trial_a;
    logic [REM_W-1:0]  trial_b;
    logic [REM_W:0]    diff;
    logic              ge;

    // one step: bring in the next dividend bit (or radicand bit pair), try a subtract
    always_comb begin
        if (r_mode == ITER_DIV) begin
            trial_a = {r_rem[REM_W-2:0], r_acc[SUM_W-1]};
            trial_b = REM_W'(r_div);
        end else begin
            trial_a = {r_rem[REM_W-3:0], r_acc[SUM_W-1 -: 2]};
            trial_b = {r_q[REM_W-3:0], 2'b01};
        end
        diff = {1'b0, trial_a} - {1'b0, trial_b};
        ge   = !diff[REM_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= (i_req.mode == ITER_DIV) ? DIV_STEPS : SQRT_STEPS;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mode <= i_req.mode;
            r_div  <= i_divisor;
            r_rem  <= '0;
            r_q    <= '0;
            if (i_req.mode == ITER_DIV) begin
                r_acc <= i_operand;
            end else begin
                r_acc <= {i_operand[RAD_W-1:0], {(SUM_W-RAD_W){1'b0}}};
            end
        end else if (r_busy && r_cnt != '0) begin
            r_rem <= ge ? diff[REM_W-1:0] : trial_a;
            r_q   <= {r_q[SUM_W-2:0], ge};
            r_acc <= (r_mode == ITER_DIV) ? (r_acc << 1) : (r_acc << 2);
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_busy && (r_cnt == '0);
    assign o_result    = r_q;

endmodule
